// ===== src/abas_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abas_pkg
// Shared widths, limits and control types of the block-average smoother.
// ----------------------------------------------------------------------------
package abas_pkg;

  // field widths
  localparam int SAMPLE_W = 10;
  localparam int ACC_W    = 15;
  localparam int AVG_W    = 10;
  localparam int MUX_W    = 3;

  // smoothing history: three previous results per channel, packed in one row
  localparam int HIST_DEPTH = 3;
  localparam int HIST_W     = HIST_DEPTH * AVG_W;

  // visible average fields on the result beat
  localparam int OUT_CH = 4;

  // stream data widths, padded to whole bytes
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_PAD_W   = OUT_TDATA_W - MUX_W - OUT_CH * AVG_W;

  // mux input wired to the reference pin, skipped by the channel sequence
  localparam int SKIPPED_MUX = 3;

  // saturation limits
  localparam logic [ACC_W-1:0] ACC_MAX = '1;
  localparam logic [AVG_W-1:0] AVG_MAX = '1;

  // per-beat control into the update datapath
  typedef struct packed {
    logic last_round;  // beat belongs to the last round of a block
    logic smooth;      // channel runs through the smoothing filter
  } calc_ctl_t;

endpackage

// ===== src/abas_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abas_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module abas_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds while idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/abas_calc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abas_calc
// Accumulate, block divide by a constant and four-point smoothing for one beat.
// ----------------------------------------------------------------------------
module abas_calc #(
  parameter int ROUNDS_PER_BLOCK = 25
) (
  input  logic [abas_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [abas_pkg::ACC_W-1:0]    acc_i,
  input  logic [abas_pkg::HIST_W-1:0]   hist_i,
  input  abas_pkg::calc_ctl_t           ctl_i,
  output logic [abas_pkg::ACC_W-1:0]    acc_o,
  output logic [abas_pkg::HIST_W-1:0]   hist_o,
  output logic [abas_pkg::AVG_W-1:0]    avg_o
);

  // reciprocal for exact truncating division of any ACC_W-bit value
  localparam int RCP_SH = abas_pkg::ACC_W + $clog2(ROUNDS_PER_BLOCK);
  localparam int RCP_W  = abas_pkg::ACC_W + 1;
  localparam int PROD_W = abas_pkg::ACC_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP_M =
    RCP_W'(((longint'(1) << RCP_SH) + longint'(ROUNDS_PER_BLOCK) - 1) /
           longint'(ROUNDS_PER_BLOCK));

  logic [abas_pkg::ACC_W:0]   acc_sum;
  logic [abas_pkg::ACC_W-1:0] acc_sat;
  logic [PROD_W-1:0]          prod;
  logic [abas_pkg::ACC_W-1:0] quo;
  logic [abas_pkg::AVG_W-1:0] blk_avg;
  logic [abas_pkg::AVG_W-1:0] h0, h1, h2;
  logic [abas_pkg::AVG_W+1:0] sm_sum;
  logic [abas_pkg::AVG_W-1:0] sm_avg;

  // saturating accumulate
  always_comb begin
    acc_sum = {1'b0, acc_i} + (abas_pkg::ACC_W + 1)'(sample_i);
    acc_sat = (acc_sum > {1'b0, abas_pkg::ACC_MAX}) ? abas_pkg::ACC_MAX
                                                    : acc_sum[abas_pkg::ACC_W-1:0];
  end

  // block average by reciprocal multiply, clamped to the average range
  always_comb begin
    prod    = PROD_W'(acc_sat) * PROD_W'(RCP_M);
    quo     = abas_pkg::ACC_W'(prod >> RCP_SH);
    blk_avg = (quo > abas_pkg::ACC_W'(abas_pkg::AVG_MAX)) ? abas_pkg::AVG_MAX
                                                          : quo[abas_pkg::AVG_W-1:0];
  end

  // four-point moving average over the new value and three previous results
  always_comb begin
    h0     = hist_i[abas_pkg::AVG_W-1:0];
    h1     = hist_i[2*abas_pkg::AVG_W-1:abas_pkg::AVG_W];
    h2     = hist_i[3*abas_pkg::AVG_W-1:2*abas_pkg::AVG_W];
    sm_sum = (abas_pkg::AVG_W + 2)'(blk_avg) + (abas_pkg::AVG_W + 2)'(h0) +
             (abas_pkg::AVG_W + 2)'(h1) + (abas_pkg::AVG_W + 2)'(h2);
    sm_avg = sm_sum[abas_pkg::AVG_W+1:2];
  end

  // write-back values: accumulator clears at the end of a block
  assign acc_o  = ctl_i.last_round ? '0 : acc_sat;
  assign hist_o = {h1, h0, sm_avg};
  assign avg_o  = ctl_i.smooth ? sm_avg : blk_avg;

endmodule

// ===== src/adc_block_average_smoother_top.sv =====
`timescale 1ns / 1ps
// path: a sample beat passes the stage 1 register and then the result register
// throughput: one sample per cycle while the result side is not stalled, set by the
//   accumulator memory read in the accept cycle and its write-back as the beat leaves stage 1
// reset: accumulators and history read as zero through per-entry valid bits
//   cleared at once; averages, channel sequence and round count restart at 0
// ----------------------------------------------------------------------------
// adc_block_average_smoother_top
// Round-robin block averager over converter channels with 4-point smoothing on the first SMOOTHED_CHANNELS.
// ----------------------------------------------------------------------------
module adc_block_average_smoother_top #(
  parameter int ROUNDS_PER_BLOCK  = 25,
  parameter int NUM_CHANNELS      = 4,
  parameter int SMOOTHED_CHANNELS = 3
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [9:0] sample
  input  logic [abas_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [2:0] next_mux_channel, [12:3] average_ch0, [22:13] average_ch1,
  // [32:23] average_ch2, [42:33] average_ch3
  output logic [abas_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // [0] averages_updated
  output logic                               m_axis_tuser
);

  localparam int CH_W  = $clog2(NUM_CHANNELS);
  localparam int RND_W = $clog2(ROUNDS_PER_BLOCK + 1);
  localparam logic [CH_W-1:0]  LAST_CH  = CH_W'(NUM_CHANNELS - 1);
  localparam logic [RND_W-1:0] LAST_RND = RND_W'(ROUNDS_PER_BLOCK - 1);
  localparam logic [CH_W:0]    SMOOTH_LIM =
    (CH_W + 1)'((SMOOTHED_CHANNELS > NUM_CHANNELS) ? NUM_CHANNELS : SMOOTHED_CHANNELS);

  typedef struct packed {
    logic [CH_W-1:0]               ch;
    logic [abas_pkg::SAMPLE_W-1:0] sample;
    logic                          last_round;
    logic                          done;
    logic [abas_pkg::MUX_W-1:0]    mux;
    logic                          acc_ok;
    logic                          hist_ok;
  } s1_t;

  logic                          in_acc;
  logic                          s1_adv;
  logic [CH_W-1:0]               cur_ch_q, cur_ch_d;
  logic [RND_W-1:0]              rnd_q, rnd_d;
  logic [CH_W-1:0]               nxt_ch;
  logic [3:0]                    mux_ext;
  logic                          s1_vld_q, s1_vld_d;
  s1_t                           s1_q, s1_d;
  logic [NUM_CHANNELS-1:0]       acc_vld_q, acc_vld_d;
  logic [NUM_CHANNELS-1:0]       hist_vld_q, hist_vld_d;
  logic [abas_pkg::ACC_W-1:0]    acc_rdata, acc_rd, acc_wr;
  logic [abas_pkg::HIST_W-1:0]   hist_rdata, hist_rd, hist_wr;
  logic                          acc_we, hist_we;
  abas_pkg::calc_ctl_t           calc_ctl;
  logic [abas_pkg::AVG_W-1:0]    new_avg;
  logic [abas_pkg::AVG_W-1:0]    latest_q [abas_pkg::OUT_CH];
  logic [abas_pkg::AVG_W-1:0]    latest_d [abas_pkg::OUT_CH];
  logic [abas_pkg::AVG_W-1:0]    pend_q   [abas_pkg::OUT_CH];
  logic [abas_pkg::AVG_W-1:0]    pend_d   [abas_pkg::OUT_CH];
  logic [3:0]                    s1_ch_ext;
  logic                          out_vld_q, out_vld_d;
  logic [abas_pkg::OUT_TDATA_W-1:0] out_data_q, out_data_d;
  logic                          out_user_q, out_user_d;

  // handshake: stage 1 moves on whenever the result register can take it
  assign s1_adv        = s1_vld_q & (~out_vld_q | m_axis_tready);
  assign s_axis_tready = ~s1_vld_q | s1_adv;
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  // channel sequence and next mux input, skipping the reference pin
  always_comb begin
    nxt_ch  = (cur_ch_q == LAST_CH) ? '0 : cur_ch_q + 1'b1;
    mux_ext = 4'(nxt_ch);
    if (mux_ext >= 4'(abas_pkg::SKIPPED_MUX)) begin
      mux_ext = mux_ext + 4'd1;
    end
  end

  // sequence and round counters
  always_comb begin
    cur_ch_d = cur_ch_q;
    rnd_d    = rnd_q;
    if (in_acc) begin
      cur_ch_d = nxt_ch;
      if (cur_ch_q == LAST_CH) begin
        rnd_d = (rnd_q == LAST_RND) ? '0 : rnd_q + 1'b1;
      end
    end
  end

  // stage 1 register: beat waits here for the memory read data
  always_comb begin
    s1_vld_d = s1_vld_q;
    s1_d     = s1_q;
    if (s1_adv) begin
      s1_vld_d = 1'b0;
    end
    if (in_acc) begin
      s1_vld_d          = 1'b1;
      s1_d.ch           = cur_ch_q;
      s1_d.sample       = s_axis_tdata[abas_pkg::SAMPLE_W-1:0];
      s1_d.last_round   = (rnd_q == LAST_RND);
      s1_d.done         = (rnd_q == LAST_RND) && (cur_ch_q == LAST_CH);
      s1_d.mux          = mux_ext[abas_pkg::MUX_W-1:0];
      s1_d.acc_ok       = acc_vld_q[cur_ch_q];
      s1_d.hist_ok      = hist_vld_q[cur_ch_q];
    end
  end

  // state memories; same-channel accesses are at least two beats apart
  abas_ram #(
    .WIDTH (abas_pkg::ACC_W),
    .DEPTH (NUM_CHANNELS)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (s1_q.ch),
    .wdata_i (acc_wr),
    .re_i    (in_acc),
    .raddr_i (cur_ch_q),
    .rdata_o (acc_rdata)
  );

  abas_ram #(
    .WIDTH (abas_pkg::HIST_W),
    .DEPTH (NUM_CHANNELS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (s1_q.ch),
    .wdata_i (hist_wr),
    .re_i    (in_acc),
    .raddr_i (cur_ch_q),
    .rdata_o (hist_rdata)
  );

  // entries never written since reset read as zero
  assign acc_rd  = s1_q.acc_ok  ? acc_rdata  : '0;
  assign hist_rd = s1_q.hist_ok ? hist_rdata : '0;

  assign calc_ctl.last_round = s1_q.last_round;
  assign calc_ctl.smooth     = ({1'b0, s1_q.ch} < SMOOTH_LIM);

  abas_calc #(
    .ROUNDS_PER_BLOCK (ROUNDS_PER_BLOCK)
  ) u_calc (
    .sample_i (s1_q.sample),
    .acc_i    (acc_rd),
    .hist_i   (hist_rd),
    .ctl_i    (calc_ctl),
    .acc_o    (acc_wr),
    .hist_o   (hist_wr),
    .avg_o    (new_avg)
  );

  // write-back and entry valid bits
  assign acc_we  = s1_adv;
  assign hist_we = s1_adv & s1_q.last_round & calc_ctl.smooth;

  always_comb begin
    acc_vld_d  = acc_vld_q;
    hist_vld_d = hist_vld_q;
    if (acc_we) begin
      acc_vld_d[s1_q.ch] = 1'b1;
    end
    if (hist_we) begin
      hist_vld_d[s1_q.ch] = 1'b1;
    end
  end

  // stage new averages per channel, publish all of them on the block's last beat
  assign s1_ch_ext = 4'(s1_q.ch);

  always_comb begin
    latest_d = latest_q;
    pend_d   = pend_q;
    if (s1_adv && s1_q.last_round) begin
      for (int i = 0; i < abas_pkg::OUT_CH; i++) begin
        if (s1_q.done && (i < NUM_CHANNELS)) begin
          latest_d[i] = pend_q[i];
        end
        if (s1_ch_ext == 4'(i)) begin
          pend_d[i] = new_avg;
          if (s1_q.done) begin
            latest_d[i] = new_avg;
          end
        end
      end
    end
  end

  // result register
  always_comb begin
    out_vld_d  = out_vld_q;
    out_data_d = out_data_q;
    out_user_d = out_user_q;
    if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    if (s1_adv) begin
      out_vld_d  = 1'b1;
      out_user_d = s1_q.done;
      out_data_d = {{abas_pkg::OUT_PAD_W{1'b0}}, latest_d[3], latest_d[2],
                    latest_d[1], latest_d[0], s1_q.mux};
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_ch_q   <= '0;
      rnd_q      <= '0;
      s1_vld_q   <= 1'b0;
      acc_vld_q  <= '0;
      hist_vld_q <= '0;
      out_vld_q  <= 1'b0;
      for (int i = 0; i < abas_pkg::OUT_CH; i++) begin
        latest_q[i] <= '0;
        pend_q[i]   <= '0;
      end
    end else begin
      cur_ch_q   <= cur_ch_d;
      rnd_q      <= rnd_d;
      s1_vld_q   <= s1_vld_d;
      acc_vld_q  <= acc_vld_d;
      hist_vld_q <= hist_vld_d;
      out_vld_q  <= out_vld_d;
      latest_q   <= latest_d;
      pend_q     <= pend_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    s1_q       <= s1_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

`ifndef SYNTHESIS
  // a completed block always leaves the sequence at channel 0
  a_done_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[abas_pkg::MUX_W-1:0] == '0)
    else $error("block completion with nonzero next mux channel");

  // a write-back never collides with a read of the same entry
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_we && in_acc |-> s1_q.ch != cur_ch_q)
    else $error("accumulator read and write-back hit the same entry");

  // a stalled beat keeps its stage 1 contents, the read data depends on it
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && !s1_adv |=> s1_vld_q && $stable(s1_q))
    else $error("stage 1 beat changed while stalled");

  // the sequence counter stays within the channel range
  a_ch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_ch_q <= LAST_CH)
    else $error("channel counter out of range");
`endif

endmodule

// ===== verif/tb_adc_block_average_smoother_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adc_block_average_smoother_top
// Streams round-robin converter samples into the block averager and checks
// every result beat against a cycle-free model of the accumulate, block
// divide and 4-point smoothing path, with random gaps on both stream sides.
// ----------------------------------------------------------------------------
module tb_adc_block_average_smoother_top;

  localparam int ROUNDS     = 25;
  localparam int NUM_CH     = 4;
  localparam int SMOOTH_CH  = 3;
  localparam int CHUNK_LEN  = 92;
  localparam int NUM_CHUNKS = 6;
  localparam int DRAIN_CYC  = 10;
  localparam int LIMIT_CYC  = 200000;

  // result beat as the model sees it
  typedef struct packed {
    logic [abas_pkg::MUX_W-1:0]                        mux;
    logic                                              updated;
    logic [abas_pkg::OUT_CH-1:0][abas_pkg::AVG_W-1:0]  avg;
  } smoother_out_t;

  // sample patterns for the random chunks
  typedef enum int {PAT_MAX, PAT_ZERO, PAT_UNIFORM, PAT_NEAR, PAT_WALK} sample_pat_e;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  // [9:0] sample
  logic [abas_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  // [2:0] next_mux_channel, [12:3] average_ch0, [22:13] average_ch1,
  // [32:23] average_ch2, [42:33] average_ch3
  logic [abas_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  // [0] averages_updated
  logic                    m_axis_tuser;

  logic [abas_pkg::SAMPLE_W-1:0] sample_q[$];
  smoother_out_t           avg_out_q[$];
  smoother_out_t           want;

  // model state
  logic [abas_pkg::ACC_W-1:0] acc_m [NUM_CH];
  logic [abas_pkg::AVG_W-1:0] hist_m [SMOOTH_CH][abas_pkg::HIST_DEPTH];
  logic [abas_pkg::AVG_W-1:0] avg_m [NUM_CH];
  int unsigned             chan_m;
  int unsigned             round_m;

  int unsigned             send_gap;
  bit                      send_burst;
  int unsigned             stall_left;
  bit                      recv_burst;
  int unsigned             cycle_cnt;
  int unsigned             fail_cnt;

  adc_block_average_smoother_top #(
    .ROUNDS_PER_BLOCK  (ROUNDS),
    .NUM_CHANNELS      (NUM_CH),
    .SMOOTHED_CHANNELS (SMOOTH_CH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // accumulate one sample, close the block after the last round
  function automatic smoother_out_t smoother_step(input logic [abas_pkg::SAMPLE_W-1:0] s);
    int unsigned   sum;
    int unsigned   blk;
    smoother_out_t r;
    sum = int'(acc_m[chan_m]) + int'(s);
    acc_m[chan_m] = (sum > abas_pkg::ACC_MAX) ? abas_pkg::ACC_MAX
                                              : sum[abas_pkg::ACC_W-1:0];
    chan_m++;
    if (chan_m >= NUM_CH) begin
      chan_m = 0;
      round_m++;
    end
    r.updated = 1'b0;
    if (round_m >= ROUNDS) begin
      for (int c = 0; c < NUM_CH; c++) begin
        blk = int'(acc_m[c]) / ROUNDS;
        if (blk > abas_pkg::AVG_MAX) blk = 32'(abas_pkg::AVG_MAX);
        if (c < SMOOTH_CH) begin
          blk = (blk + hist_m[c][0] + hist_m[c][1] + hist_m[c][2]) / 4;
          if (blk > abas_pkg::AVG_MAX) blk = 32'(abas_pkg::AVG_MAX);
          hist_m[c][2] = hist_m[c][1];
          hist_m[c][1] = hist_m[c][0];
          hist_m[c][0] = blk[abas_pkg::AVG_W-1:0];
        end
        avg_m[c] = blk[abas_pkg::AVG_W-1:0];
        acc_m[c] = '0;
      end
      round_m = 0;
      r.updated = 1'b1;
    end
    // mux input 3 is the reference pin and never selected
    r.mux = (chan_m < abas_pkg::SKIPPED_MUX) ? chan_m[abas_pkg::MUX_W-1:0]
                                             : (abas_pkg::MUX_W)'(chan_m + 1);
    for (int c = 0; c < abas_pkg::OUT_CH; c++)
      r.avg[c] = (c < NUM_CH) ? avg_m[c] : '0;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  // sample driver, one draw of idle cycles per beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      send_gap = 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (send_gap != 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (sample_q.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(abas_pkg::IN_TDATA_W-abas_pkg::SAMPLE_W){1'b0}},
                          sample_q.pop_front()};
        if ($urandom_range(0, 19) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 9);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result sink, stalls drawn per accepted beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if ($urandom_range(0, 19) == 0) recv_burst = !recv_burst;
      stall_left = recv_burst ? 0 : $urandom_range(0, 9);
      m_axis_tready <= (stall_left == 0);
    end else if (!m_axis_tready) begin
      if (stall_left > 1) begin
        stall_left--;
      end else begin
        stall_left = 0;
        m_axis_tready <= 1'b1;
      end
    end
  end

  // predict on each sample beat, compare on each result beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        avg_out_q.push_back(smoother_step(s_axis_tdata[abas_pkg::SAMPLE_W-1:0]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (avg_out_q.size() == 0) begin
          $error("result beat with no sample pending");
          fail_cnt++;
        end else begin
          want = avg_out_q.pop_front();
          check_field("next_mux_channel", want.mux, m_axis_tdata[2:0]);
          check_field("averages_updated", want.updated, m_axis_tuser);
          check_field("average_ch0", want.avg[0], m_axis_tdata[12:3]);
          check_field("average_ch1", want.avg[1], m_axis_tdata[22:13]);
          check_field("average_ch2", want.avg[2], m_axis_tdata[32:23]);
          check_field("average_ch3", want.avg[3], m_axis_tdata[42:33]);
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYC) begin
      $display("[adc_block_average_smoother_top] ERROR");
      $finish;
    end
  end

  initial begin
    sample_pat_e                   pat;
    logic [abas_pkg::SAMPLE_W-1:0] base [NUM_CH];
    int                            v;

    // model reset
    for (int c = 0; c < NUM_CH; c++) begin
      acc_m[c] = '0;
      avg_m[c] = '0;
    end
    for (int c = 0; c < SMOOTH_CH; c++)
      for (int d = 0; d < abas_pkg::HIST_DEPTH; d++) hist_m[c][d] = '0;
    chan_m     = 0;
    round_m    = 0;
    fail_cnt   = 0;
    cycle_cnt  = 0;
    send_burst = 1'b0;
    recv_burst = 1'b0;

    // directed: field extremes on every channel, alternating bit patterns on channels 2 and 3
    sample_q.push_back(10'h000); sample_q.push_back(10'h3ff);
    sample_q.push_back(10'h155); sample_q.push_back(10'h2aa);
    sample_q.push_back(10'h3ff); sample_q.push_back(10'h000);
    sample_q.push_back(10'h2aa); sample_q.push_back(10'h155);
    sample_q.push_back(10'h001); sample_q.push_back(10'h200);
    sample_q.push_back(10'h3fe); sample_q.push_back(10'h1ff);
    sample_q.push_back(10'h3ff); sample_q.push_back(10'h3ff);
    sample_q.push_back(10'h3ff); sample_q.push_back(10'h3ff);
    sample_q.push_back(10'h000); sample_q.push_back(10'h000);
    sample_q.push_back(10'h000); sample_q.push_back(10'h000);

    // random chunks; full scale first and zero next
    for (int k = 0; k < NUM_CHUNKS; k++) begin
      if (k == 0) pat = PAT_MAX;
      else if (k == 1) pat = PAT_ZERO;
      else pat = sample_pat_e'($urandom_range(PAT_UNIFORM, PAT_WALK));
      for (int c = 0; c < NUM_CH; c++)
        base[c] = (abas_pkg::SAMPLE_W)'($urandom_range(0, 1023));
      for (int n = 0; n < CHUNK_LEN; n++) begin
        case (pat)
          PAT_MAX:  v = 1023;
          PAT_ZERO: v = 0;
          PAT_NEAR: begin
            v = int'(base[n % NUM_CH]) + $urandom_range(0, 15) - 8;
            if (v < 0) v = 0;
            if (v > 1023) v = 1023;
          end
          PAT_WALK: begin
            v = 1 << $urandom_range(0, abas_pkg::SAMPLE_W - 1);
            if ($urandom_range(0, 1)) v = ~v & 1023;
          end
          default:  v = $urandom_range(0, 1023);
        endcase
        sample_q.push_back(v[abas_pkg::SAMPLE_W-1:0]);
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain: all samples taken, all results seen, then settle
    while (sample_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (avg_out_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("[adc_block_average_smoother_top] OK");
    end else begin
      $display("[adc_block_average_smoother_top] ERROR");
    end
    $finish;
  end

endmodule
